// ===== rtl/dhl_pkg.sv =====
// Shared constants and types for the DH link transform pipeline.
package dhl_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;            // fraction bits of angles, lengths, rotations
  localparam int INT_FRAC  = 30;            // fraction bits inside the CORDIC
  localparam int FIELD_W   = 24;            // angle / length field width
  localparam int ROT_W     = 18;            // rotation entry field width
  localparam int UNIT_W    = FRAC_BITS + 2; // internal +-1.0 values
  localparam int CW        = 32;            // CORDIC datapath width (Q2.30)
  localparam int SHIFT_Q   = INT_FRAC - FRAC_BITS;
  localparam int CORDIC_ITERS = 24;

  // Angle reduction widths
  localparam int MAG_W    = FIELD_W;                 // |angle|, up to 2^(FIELD_W-1)
  localparam int IP_W     = FIELD_W + 1 - FRAC_BITS; // integer part of |angle|
  localparam int M_W      = FIELD_W + SHIFT_Q;       // |angle| in Q30
  localparam int R_W      = INT_FRAC + 4;            // remainder, below 4*pi in Q30
  localparam int RED_W    = (M_W > R_W) ? M_W : R_W;
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = 14;

  localparam logic [R_W-1:0] TWO_PI_Q  = R_W'(64'd6746518852);
  localparam logic [R_W-1:0] PI_Q      = R_W'(64'd3373259426);
  localparam logic [R_W-1:0] HALF_PI_Q = R_W'(64'd1686629713);
  // 2^(30+16) / (2*pi in Q30), rounded down: quotient estimate never overshoots
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << (INT_FRAC + RECIP_SH)) / 64'd6746518852);

  localparam logic signed [CW-1:0] CORDIC_X0 = 32'sh26DD3B6A;
  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F};

  // Pipeline depths
  localparam int RED_STAGES  = 4;
  localparam int TRIG_STAGES = CORDIC_ITERS + 2;
  localparam int MAT_STAGES  = 3;
  localparam int D_LEN       = 1 + RED_STAGES + TRIG_STAGES;
  localparam int LATENCY     = D_LEN + MAT_STAGES;

  // Configuration register map
  localparam int CFG_AW = 3;
  typedef enum logic [CFG_AW-1:0] {
    REG_PRISMATIC    = 3'd0,
    REG_OFFSET       = 3'd1,
    REG_MIN          = 3'd2,
    REG_MAX          = 3'd3,
    REG_FIXED_ANGLE  = 3'd4,
    REG_FIXED_LENGTH = 3'd5,
    REG_LINK_LENGTH  = 3'd6,
    REG_LINK_TWIST   = 3'd7
  } cfg_reg_t;

  // Reduced angle handed to the CORDIC
  typedef struct packed {
    logic signed [CW-1:0] z;
    logic                 neg;
  } ang_t;

  // Cosine and sine of one angle
  typedef struct packed {
    logic signed [UNIT_W-1:0] c;
    logic signed [UNIT_W-1:0] s;
  } trig_t;

  // One result item
  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [ROT_W-1:0]   m22;
    logic signed [ROT_W-1:0]   m21;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [ROT_W-1:0]   m12;
    logic signed [ROT_W-1:0]   m11;
    logic signed [ROT_W-1:0]   m10;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [ROT_W-1:0]   m02;
    logic signed [ROT_W-1:0]   m01;
    logic signed [ROT_W-1:0]   m00;
  } mat_t;

endpackage

// ===== rtl/dhl_reduce.sv =====
// Four-stage reduction of an angle modulo 2*pi and fold into [-pi/2, pi/2].
module dhl_reduce import dhl_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [FIELD_W-1:0] angle,
  output ang_t                      red
);

  // Stage 1: magnitude and quotient estimate
  logic [MAG_W-1:0]          mag_c;
  logic [IP_W-1:0]           ip_c;
  logic [IP_W+RECIP_W-1:0]   est_c;
  logic                      sgn1;
  logic [MAG_W-1:0]          mag1;
  logic [IP_W-1:0]           quo1;

  assign mag_c = angle[FIELD_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
  assign ip_c  = IP_W'(mag_c >> FRAC_BITS);
  assign est_c = (IP_W+RECIP_W)'(ip_c) * (IP_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1 <= angle[FIELD_W-1];
      mag1 <= mag_c;
      quo1 <= IP_W'(est_c >> RECIP_SH);
    end
  end

  // Stage 2: remainder, off by at most one period
  logic [RED_W-1:0] m_c;
  logic [RED_W-1:0] prod_c;
  logic [RED_W-1:0] diff_c;
  logic             sgn2;
  logic [R_W-1:0]   rem2;

  assign m_c    = RED_W'(mag1) << SHIFT_Q;
  assign prod_c = RED_W'(quo1) * RED_W'(TWO_PI_Q);
  assign diff_c = m_c - prod_c;

  always_ff @(posedge clk) begin
    if (en) begin
      sgn2 <= sgn1;
      rem2 <= R_W'(diff_c);
    end
  end

  // Stage 3: final correction into [0, 2*pi)
  logic           sgn3;
  logic [R_W-1:0] rem3;

  always_ff @(posedge clk) begin
    if (en) begin
      sgn3 <= sgn2;
      rem3 <= (rem2 >= TWO_PI_Q) ? rem2 - TWO_PI_Q : rem2;
    end
  end

  // Stage 4: fold; the folded half turn negates sine and cosine
  logic [R_W-1:0] base_c;
  logic           neg_c;
  logic [R_W:0]   z_c;

  always_comb begin
    if (rem3 <= HALF_PI_Q) begin
      base_c = '0;
      neg_c  = 1'b0;
    end else if (rem3 < TWO_PI_Q - HALF_PI_Q) begin
      base_c = PI_Q;
      neg_c  = 1'b1;
    end else begin
      base_c = TWO_PI_Q;
      neg_c  = 1'b0;
    end
    z_c = sgn3 ? ((R_W+1)'(base_c) - (R_W+1)'(rem3))
               : ((R_W+1)'(rem3) - (R_W+1)'(base_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red.z   <= CW'(z_c);
      red.neg <= neg_c;
    end
  end

endmodule

// ===== rtl/dhl_cordic.sv =====
// Pipelined rotation-mode CORDIC: one iteration per stage, then round and sign fix.
module dhl_cordic import dhl_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ang_t  red,
  output trig_t trig
);

  localparam logic signed [CW:0] RND_Q = (CW+1)'(1) <<< (SHIFT_Q - 1);
  localparam logic signed [CW:0] ONE_Q = (CW+1)'(1) <<< FRAC_BITS;

  function automatic logic signed [UNIT_W-1:0] unit_q(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    t = ((CW+1)'(v) + RND_Q) >>> SHIFT_Q;
    if (t > ONE_Q) begin
      t = ONE_Q;
    end else if (t < -ONE_Q) begin
      t = -ONE_Q;
    end
    return UNIT_W'(t);
  endfunction

  logic signed [CW-1:0] xr [CORDIC_ITERS];
  logic signed [CW-1:0] yr [CORDIC_ITERS];
  logic signed [CW-1:0] zr [CORDIC_ITERS];
  logic                 nr [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic                 n_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = red.z;
      assign n_in = red.neg;
    end else begin : g_rest
      assign x_in = xr[i-1];
      assign y_in = yr[i-1];
      assign z_in = zr[i-1];
      assign n_in = nr[i-1];
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        nr[i] <= n_in;
        if (!z_in[CW-1]) begin
          xr[i] <= x_in - (y_in >>> i);
          yr[i] <= y_in + (x_in >>> i);
          zr[i] <= z_in - ATAN_TAB[i];
        end else begin
          xr[i] <= x_in + (y_in >>> i);
          yr[i] <= y_in - (x_in >>> i);
          zr[i] <= z_in + ATAN_TAB[i];
        end
      end
    end
  end

  // Round to FRAC_BITS and clamp, then undo the fold
  logic signed [UNIT_W-1:0] c1, s1;
  logic                     n1;

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= unit_q(xr[CORDIC_ITERS-1]);
      s1 <= unit_q(yr[CORDIC_ITERS-1]);
      n1 <= nr[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig.c <= n1 ? -c1 : c1;
      trig.s <= n1 ? -s1 : s1;
    end
  end

endmodule

// ===== rtl/dhl_matrix.sv =====
// Three-stage matrix assembly: products, round and saturate, negate into the output register.
module dhl_matrix import dhl_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  trig_t                     th,
  input  trig_t                     al,
  input  logic signed [FIELD_W-1:0] link_length,
  input  logic signed [FIELD_W-1:0] d,
  output mat_t                      res
);

  localparam int PR_W = 2 * UNIT_W;
  localparam int PP_W = FIELD_W + UNIT_W;
  localparam logic signed [PR_W-1:0] RND_R   = PR_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PR_W-1:0] ONE_R   = PR_W'(1) <<< FRAC_BITS;
  localparam logic signed [PP_W-1:0] RND_P   = PP_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PP_W-1:0] POS_MAX = (PP_W'(1) <<< (FIELD_W - 1)) - PP_W'(1);
  localparam logic signed [PP_W-1:0] POS_MIN = -(PP_W'(1) <<< (FIELD_W - 1));

  function automatic logic signed [UNIT_W-1:0] rnd_rot(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0] t;
    t = (p + RND_R) >>> FRAC_BITS;
    if (t > ONE_R) begin
      t = ONE_R;
    end else if (t < -ONE_R) begin
      t = -ONE_R;
    end
    return UNIT_W'(t);
  endfunction

  function automatic logic signed [FIELD_W-1:0] rnd_pos(input logic signed [PP_W-1:0] p);
    logic signed [PP_W-1:0] t;
    t = (p + RND_P) >>> FRAC_BITS;
    if (t > POS_MAX) begin
      t = POS_MAX;
    end else if (t < POS_MIN) begin
      t = POS_MIN;
    end
    return FIELD_W'(t);
  endfunction

  // Stage 1: exact products
  logic signed [PR_W-1:0]    p01, p02, p11, p12;
  logic signed [PP_W-1:0]    px, py;
  trig_t                     th1, al1;
  logic signed [FIELD_W-1:0] d1;

  always_ff @(posedge clk) begin
    if (en) begin
      p01 <= PR_W'(th.s) * PR_W'(al.c);
      p02 <= PR_W'(th.s) * PR_W'(al.s);
      p11 <= PR_W'(th.c) * PR_W'(al.c);
      p12 <= PR_W'(th.c) * PR_W'(al.s);
      px  <= PP_W'(link_length) * PP_W'(th.c);
      py  <= PP_W'(link_length) * PP_W'(th.s);
      th1 <= th;
      al1 <= al;
      d1  <= d;
    end
  end

  // Stage 2: round half up and saturate
  logic signed [UNIT_W-1:0]  r01, r02, r11, r12;
  logic signed [FIELD_W-1:0] rx, ry;
  trig_t                     th2, al2;
  logic signed [FIELD_W-1:0] d2;

  always_ff @(posedge clk) begin
    if (en) begin
      r01 <= rnd_rot(p01);
      r02 <= rnd_rot(p02);
      r11 <= rnd_rot(p11);
      r12 <= rnd_rot(p12);
      rx  <= rnd_pos(px);
      ry  <= rnd_pos(py);
      th2 <= th1;
      al2 <= al1;
      d2  <= d1;
    end
  end

  // Stage 3: negated entries, output register
  always_ff @(posedge clk) begin
    if (en) begin
      res.m00   <= ROT_W'(th2.c);
      res.m01   <= ROT_W'(-r01);
      res.m02   <= ROT_W'(r02);
      res.pos_x <= rx;
      res.m10   <= ROT_W'(th2.s);
      res.m11   <= ROT_W'(r11);
      res.m12   <= ROT_W'(-r12);
      res.pos_y <= ry;
      res.m21   <= ROT_W'(al2.s);
      res.m22   <= ROT_W'(al2.c);
      res.pos_z <= d2;
    end
  end

endmodule

// ===== rtl/dh_link_transform_top.sv =====
// Top level of the Denavit-Hartenberg link transform pipeline.
//
//  channel   | direction | width | contents
//  ----------+-----------+-------+------------------------------------------------
//  s_axis    | in        | 24    | joint_value, Q8.16
//  m_axis    | out       | 216   | m00 m01 m02 pos_x m10 m11 m12 pos_y m21 m22 pos_z
//  cfg       | in        | 24    | write-only register port, index 0..7
//
// One item enters per cycle unless the output stalls; results leave in input order.
// Depth: 1 joint stage, 4 angle-reduction stages, 24 CORDIC iterations, 2 rounding
// stages and 3 matrix stages, the last being the output register.
// All stages advance together whenever the output register is empty or being taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// Reset (rst, synchronous) clears the valid bits and all configuration registers,
// and holds s_axis_tready low while it is asserted.
module dh_link_transform_top import dhl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // [23:0] joint_value
  input  logic [FIELD_W-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [17:0] m00, [35:18] m01, [53:36] m02, [77:54] pos_x, [95:78] m10,
  // [113:96] m11, [131:114] m12, [155:132] pos_y, [173:156] m21,
  // [191:174] m22, [215:192] pos_z
  output logic [$bits(mat_t)-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [FIELD_W-1:0]  cfg_wdata
);

  localparam logic signed [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  // Configuration registers
  logic                      joint_is_prismatic;
  logic signed [FIELD_W-1:0] joint_offset, joint_min, joint_max;
  logic signed [FIELD_W-1:0] fixed_angle, fixed_length, link_length, link_twist;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_is_prismatic <= 1'b0;
      joint_offset       <= '0;
      joint_min          <= '0;
      joint_max          <= '0;
      fixed_angle        <= '0;
      fixed_length       <= '0;
      link_length        <= '0;
      link_twist         <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PRISMATIC:    joint_is_prismatic <= cfg_wdata[0];
        REG_OFFSET:       joint_offset       <= cfg_wdata;
        REG_MIN:          joint_min          <= cfg_wdata;
        REG_MAX:          joint_max          <= cfg_wdata;
        REG_FIXED_ANGLE:  fixed_angle        <= cfg_wdata;
        REG_FIXED_LENGTH: fixed_length       <= cfg_wdata;
        REG_LINK_LENGTH:  link_length        <= cfg_wdata;
        REG_LINK_TWIST:   link_twist         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output register is stuck
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  // Valid bits travel alongside the data, one per stage
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld[LATENCY-1];

  // Joint stage: add offset with saturation, apply limits when enabled,
  // then pick which DH parameter the joint drives.
  logic signed [FIELD_W:0]   sum_c;
  logic signed [FIELD_W-1:0] sat_c, q_c, theta_c, d_c;

  always_comb begin
    sum_c = (FIELD_W+1)'($signed(s_axis_tdata)) + (FIELD_W+1)'(joint_offset);
    if (sum_c[FIELD_W] != sum_c[FIELD_W-1]) begin
      sat_c = sum_c[FIELD_W] ? F_MIN : F_MAX;
    end else begin
      sat_c = FIELD_W'(sum_c);
    end
    q_c = sat_c;
    if (joint_min < joint_max) begin
      if (sat_c < joint_min) begin
        q_c = joint_min;
      end else if (sat_c > joint_max) begin
        q_c = joint_max;
      end
    end
    theta_c = joint_is_prismatic ? fixed_angle : q_c;
    d_c     = joint_is_prismatic ? q_c : fixed_length;
  end

  logic signed [FIELD_W-1:0] theta1;
  logic signed [FIELD_W-1:0] d_dly [D_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      theta1   <= theta_c;
      d_dly[0] <= d_c;
    end
  end

  // Hold d alongside the trig lanes until the matrix stage
  for (genvar k = 1; k < D_LEN; k++) begin : g_d
    always_ff @(posedge clk) begin
      if (en) begin
        d_dly[k] <= d_dly[k-1];
      end
    end
  end

  // Trig lanes theta, twist alpha; user keeps alpha static while items are in flight
  ang_t  red_th, red_al;
  trig_t trig_th, trig_al;
  mat_t  res;

  dhl_reduce u_red_th (
    .clk   (clk),
    .en    (en),
    .angle (theta1),
    .red   (red_th)
  );

  dhl_reduce u_red_al (
    .clk   (clk),
    .en    (en),
    .angle (link_twist),
    .red   (red_al)
  );

  dhl_cordic u_cordic_th (
    .clk  (clk),
    .en   (en),
    .red  (red_th),
    .trig (trig_th)
  );

  dhl_cordic u_cordic_al (
    .clk  (clk),
    .en   (en),
    .red  (red_al),
    .trig (trig_al)
  );

  dhl_matrix u_matrix (
    .clk         (clk),
    .en          (en),
    .th          (trig_th),
    .al          (trig_al),
    .link_length (link_length),
    .d           (d_dly[D_LEN-1]),
    .res         (res)
  );

  assign m_axis_tdata = {res.pos_z, res.m22, res.m21, res.pos_y, res.m12, res.m11,
                         res.m10, res.pos_x, res.m02, res.m01, res.m00};

endmodule
